// ===== rtl/vba_pkg.sv =====
`default_nettype none

package vba_pkg;

    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 5;
    localparam int REQ_W     = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_Z = 3'd5;

    localparam logic [CFG_W-1:0] SIZE_RESET  = 6'd32;
    localparam logic [CFG_W-1:0] BLOCK_RESET = 6'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } vba_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/vba_div.sv =====
`default_nettype none

module vba_div
    import vba_pkg::*;
#(
    parameter int DW = 32,
    parameter int NW = 18
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [NW-1:0] divisor,
    output vba_div_stat_t      stat,
    output logic      [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [NW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NW:0]      shifted;
    logic [NW:0]      diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[NW]) begin
                rem_next = diff[NW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = shifted[NW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/voxel_block_averager_3d.sv =====
// Channel   | Direction | Ports
// ----------+-----------+------------------------------------------------------------
// input     | in        | s_valid, s_ready, s_req_type, s_pos_x/y/z, s_voxel_in
// result    | out       | m_valid, m_ready, m_voxel_out, m_status
// config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A load, an unused code, an out-of-range access or a run over an empty volume sets its result
// beat in the cycle after it is taken; an in-range read passes through the read state first,
// as the voxel memory has registered read data. Any other run forms the tile volume, then for
// each tile walks the voxel memory once to sum and once to write the mean back, with a divide
// between the two walks; the divider retires one quotient bit per cycle.
// Reset clears control state and the registers to their listed values; the voxel memory is
// not cleared and holds nothing defined until loaded. No item is taken while a read or a run is
// busy or while a result beat waits on m_ready.
`default_nettype none

module voxel_block_averager_3d
    import vba_pkg::*;
#(
    parameter int MAX_SIDE   = 32,
    parameter int VOXEL_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [REQ_W-1:0]      s_req_type,
    input  wire logic [POS_W-1:0]      s_pos_x,
    input  wire logic [POS_W-1:0]      s_pos_y,
    input  wire logic [POS_W-1:0]      s_pos_z,
    input  wire logic [VOXEL_BITS-1:0] s_voxel_in,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [VOXEL_BITS-1:0] m_voxel_out,
    output logic                       m_status,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int LW   = $clog2(MAX_SIDE);
    localparam int AW   = 3 * LW;
    localparam int EW   = $clog2(MAX_SIDE + 64);
    localparam int SUMW = VOXEL_BITS + AW;
    localparam int NW   = 3 * CFG_W;
    localparam int DW   = ((SUMW > NW) ? SUMW : NW) + 1;
    localparam int PW   = 2 * CFG_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_TILE  = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_DIVGO = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_WRITE = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [CFG_W-1:0]      size_x_reg, size_y_reg, size_z_reg;
    logic [CFG_W-1:0]      block_x_reg, block_y_reg, block_z_reg;
    logic [EW-1:0]         x0_reg, x0_next, y0_reg, y0_next, z0_reg, z0_next;
    logic [EW-1:0]         ex_reg, ex_next, ey_reg, ey_next, ez_reg, ez_next;
    logic [EW-1:0]         i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [SUMW-1:0]       sum_reg, sum_next;
    logic [VOXEL_BITS-1:0] mean_reg, mean_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VOXEL_BITS-1:0] m_voxel_reg, m_voxel_next;
    logic                  m_status_reg, m_status_next;

    logic [VOXEL_BITS-1:0] mem [0:(2**AW)-1];
    logic [VOXEL_BITS-1:0] mem_q_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [VOXEL_BITS-1:0] mem_wdata;

    logic [EW-1:0]         sx_eff, sy_eff, sz_eff;
    logic [CFG_W-1:0]      bx_eff, by_eff, bz_eff;
    logic [EW-1:0]         bx_e, by_e, bz_e;
    logic                  s_accept, in_range, any_empty;
    logic                  i_last, j_last, k_last;
    logic                  div_start;
    logic [DW-1:0]         div_dividend;
    logic [DW-1:0]         div_quotient;
    vba_div_stat_t         div_stat;
    logic [AW-1:0]         walk_addr, pos_addr;

    always_comb begin
        sx_eff = (EW'(size_x_reg) > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : EW'(size_x_reg);
        sy_eff = (EW'(size_y_reg) > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : EW'(size_y_reg);
        sz_eff = (EW'(size_z_reg) > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : EW'(size_z_reg);
        bx_eff = (block_x_reg == '0) ? CFG_W'(1) : block_x_reg;
        by_eff = (block_y_reg == '0) ? CFG_W'(1) : block_y_reg;
        bz_eff = (block_z_reg == '0) ? CFG_W'(1) : block_z_reg;
        bx_e   = EW'(bx_eff);
        by_e   = EW'(by_eff);
        bz_e   = EW'(bz_eff);
    end

    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign in_range  = (EW'(s_pos_x) < sx_eff) && (EW'(s_pos_y) < sy_eff)
                       && (EW'(s_pos_z) < sz_eff);
    assign any_empty = (sx_eff == '0) || (sy_eff == '0) || (sz_eff == '0);
    assign i_last    = (i_reg + EW'(1)) == ex_reg;
    assign j_last    = (j_reg + EW'(1)) == ey_reg;
    assign k_last    = (k_reg + EW'(1)) == ez_reg;
    assign walk_addr = {LW'(k_reg), LW'(j_reg), LW'(i_reg)};
    assign pos_addr  = {LW'(s_pos_z), LW'(s_pos_y), LW'(s_pos_x)};
    assign div_start = (state_reg == S_DIVGO);
    assign div_dividend = DW'(sum_reg) + DW'(n_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg  <= SIZE_RESET;
            size_y_reg  <= SIZE_RESET;
            size_z_reg  <= SIZE_RESET;
            block_x_reg <= BLOCK_RESET;
            block_y_reg <= BLOCK_RESET;
            block_z_reg <= BLOCK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SIZE_X:  size_x_reg  <= cfg_data;
                CFG_SIZE_Y:  size_y_reg  <= cfg_data;
                CFG_SIZE_Z:  size_z_reg  <= cfg_data;
                CFG_BLOCK_X: block_x_reg <= cfg_data;
                CFG_BLOCK_Y: block_y_reg <= cfg_data;
                CFG_BLOCK_Z: block_z_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        x0_next       = x0_reg;
        y0_next       = y0_reg;
        z0_next       = z0_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        ez_next       = ez_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        prod_next     = prod_reg;
        n_next        = n_reg;
        sum_next      = sum_reg;
        mean_next     = mean_reg;
        rd_pend_next  = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_voxel_next  = m_voxel_reg;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;
        mem_waddr     = walk_addr;
        mem_wdata     = mean_reg;
        mem_raddr     = walk_addr;

        if (rd_pend_reg) begin
            sum_next = sum_reg + SUMW'(mem_q_reg);
        end

        unique case (state_reg)
            S_IDLE: begin
                mem_raddr = pos_addr;
                mem_waddr = pos_addr;
                mem_wdata = s_voxel_in;
                if (s_accept) begin
                    m_voxel_next  = '0;
                    m_status_next = 1'b0;
                    priority if ((s_req_type == REQ_LOAD) || (s_req_type == REQ_READ)) begin
                        if (!in_range) begin
                            m_valid_next  = 1'b1;
                            m_status_next = 1'b1;
                        end else if (s_req_type == REQ_LOAD) begin
                            mem_we       = 1'b1;
                            m_valid_next = 1'b1;
                        end else begin
                            state_next = S_READ;
                        end
                    end else if (s_req_type == REQ_RUN) begin
                        if (any_empty) begin
                            m_valid_next = 1'b1;
                        end else begin
                            x0_next    = '0;
                            y0_next    = '0;
                            z0_next    = '0;
                            state_next = S_MUL1;
                        end
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_READ: begin
                m_valid_next = 1'b1;
                m_voxel_next = mem_q_reg;
                state_next   = S_IDLE;
            end
            S_MUL1: begin
                prod_next  = PW'(bx_eff) * PW'(by_eff);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                n_next     = NW'(prod_reg) * NW'(bz_eff);
                state_next = S_TILE;
            end
            S_TILE: begin
                ex_next    = ((x0_reg + bx_e) < sx_eff) ? (x0_reg + bx_e) : sx_eff;
                ey_next    = ((y0_reg + by_e) < sy_eff) ? (y0_reg + by_e) : sy_eff;
                ez_next    = ((z0_reg + bz_e) < sz_eff) ? (z0_reg + bz_e) : sz_eff;
                i_next     = x0_reg;
                j_next     = y0_reg;
                k_next     = z0_reg;
                sum_next   = '0;
                state_next = S_SUM;
            end
            S_SUM, S_WRITE: begin
                if (state_reg == S_SUM) begin
                    rd_pend_next = 1'b1;
                end else begin
                    mem_we = 1'b1;
                end
                if (!k_last) begin
                    k_next = k_reg + EW'(1);
                end else begin
                    k_next = z0_reg;
                    if (!j_last) begin
                        j_next = j_reg + EW'(1);
                    end else begin
                        j_next = y0_reg;
                        if (!i_last) begin
                            i_next = i_reg + EW'(1);
                        end else begin
                            i_next     = x0_reg;
                            state_next = (state_reg == S_SUM) ? S_DRAIN : S_NEXT;
                        end
                    end
                end
            end
            S_DRAIN: begin
                state_next = S_DIVGO;
            end
            S_DIVGO: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    mean_next  = div_quotient[VOXEL_BITS-1:0];
                    state_next = S_WRITE;
                end
            end
            S_NEXT: begin
                state_next = S_TILE;
                if ((z0_reg + bz_e) < sz_eff) begin
                    z0_next = z0_reg + bz_e;
                end else begin
                    z0_next = '0;
                    if ((y0_reg + by_e) < sy_eff) begin
                        y0_next = y0_reg + by_e;
                    end else begin
                        y0_next = '0;
                        if ((x0_reg + bx_e) < sx_eff) begin
                            x0_next = x0_reg + bx_e;
                        end else begin
                            x0_next       = '0;
                            m_valid_next  = 1'b1;
                            m_voxel_next  = '0;
                            m_status_next = 1'b0;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        z0_reg       <= z0_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        ez_reg       <= ez_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        prod_reg     <= prod_next;
        n_reg        <= n_next;
        sum_reg      <= sum_next;
        mean_reg     <= mean_next;
        m_voxel_reg  <= m_voxel_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    vba_div #(
        .DW (DW),
        .NW (NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign m_valid     = m_valid_reg;
    assign m_voxel_out = m_voxel_reg;
    assign m_status    = m_status_reg;

    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_req_type == REQ_LOAD) |=> m_valid)
        else $error("A load beat produced no result beat.");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy && (n_reg != '0))
        else $error("Divider started while busy or with a zero divisor.");

    a_walk_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM || state_reg == S_WRITE)
            |-> (i_reg < ex_reg) && (j_reg < ey_reg) && (k_reg < ez_reg))
        else $error("Tile walk left the tile.");

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !m_valid_reg)
        else $error("Read result would overwrite a waiting result beat.");

endmodule

`default_nettype wire
